// File: design/rmpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmpm_pkg;

  // Datapath operation codes
  localparam logic [3:0] OP_NONE      = 4'd0;
  localparam logic [3:0] OP_DIV_INIT  = 4'd1;
  localparam logic [3:0] OP_DIV_STEP  = 4'd2;
  localparam logic [3:0] OP_DIV_STORE = 4'd3;
  localparam logic [3:0] OP_NUM_MUL   = 4'd4;
  localparam logic [3:0] OP_LOG_LOAD  = 4'd5;
  localparam logic [3:0] OP_LOG_NORM  = 4'd6;
  localparam logic [3:0] OP_LOG_MLOAD = 4'd7;
  localparam logic [3:0] OP_LOG_SQ    = 4'd8;
  localparam logic [3:0] OP_LOG_FIX   = 4'd9;
  localparam logic [3:0] OP_LOG_STORE = 4'd10;
  localparam logic [3:0] OP_PSNR_DL   = 4'd11;
  localparam logic [3:0] OP_PSNR_LO   = 4'd12;
  localparam logic [3:0] OP_PSNR_HI   = 4'd13;
  localparam logic [3:0] OP_PSNR_SUM  = 4'd14;
  localparam logic [3:0] OP_OUT       = 4'd15;

  localparam int LOG_FRAC = 24;
  localparam int MSE_W    = 31;
  localparam int PSNR_W   = 15;

  // 255*255*3
  localparam logic [17:0] PEAK_X3 = 18'd195075;
  // 10*log10(2)*256 in Q24, split in two 17-bit halves
  localparam logic [33:0] PSNR_SCALE = 34'd12929139865;
  localparam logic [16:0] PS_LO = PSNR_SCALE[16:0];
  localparam logic [16:0] PS_HI = PSNR_SCALE[33:17];
  localparam logic [PSNR_W-1:0] PSNR_MAX = 15'd32767;

  typedef struct packed {
    logic       accept;
    logic       snap;
    logic [3:0] op;
    logic [1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic norm_top;
    logic tot_zero;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: design/rgb_mse_psnr_meter.sv
`timescale 1ns / 1ps
`default_nettype none
// Image quality meter over a stream of RGB pixel pairs.
// Input channel: in_valid/in_stall with the original and processed pixel and
// in_final_pixel on the last pixel of an image. Non-final pixels are taken one
// per cycle while in_stall is low; up to 2^MPL pixels (MPL = MAX_PIXELS_LOG2)
// each add their squared channel differences to running sums. When the final
// pixel is taken, in_stall rises and the controller runs the datapath: three
// restoring divisions (one quotient bit a cycle, MPL+32 steps each), then two
// fixed-point log2 evaluations, each a normalizing shift of one bit a cycle
// followed by 24 square-and-compare iterations, then the PSNR scale steps.
// A zero total error skips the logs and reports psnr_infinite.
// The result item sits in an output register (out_valid/out_stall); the next
// image's pixels are taken while it waits, but a finished result holds the
// block until the register frees.
// Reset (rst_n low, synchronous) clears the sums, the count and out_valid.
module rgb_mse_psnr_meter import rmpm_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_orig_red,
  input  wire logic [7:0]        in_orig_green,
  input  wire logic [7:0]        in_orig_blue,
  input  wire logic [7:0]        in_proc_red,
  input  wire logic [7:0]        in_proc_green,
  input  wire logic [7:0]        in_proc_blue,
  input  wire logic              in_final_pixel,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [MSE_W-1:0]       out_mse_red,
  output logic [MSE_W-1:0]       out_mse_green,
  output logic [MSE_W-1:0]       out_mse_blue,
  output logic [PSNR_W-1:0]      out_psnr_db,
  output logic                   out_psnr_infinite
);

  cmd_t  cmd;
  stat_t stat;

  rmpm_ctrl #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_final_pixel (in_final_pixel),
    .in_stall       (in_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  rmpm_datapath #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .orig_red          (in_orig_red),
    .orig_green        (in_orig_green),
    .orig_blue         (in_orig_blue),
    .proc_red          (in_proc_red),
    .proc_green        (in_proc_green),
    .proc_blue         (in_proc_blue),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_mse_red       (out_mse_red),
    .out_mse_green     (out_mse_green),
    .out_mse_blue      (out_mse_blue),
    .out_psnr_db       (out_psnr_db),
    .out_psnr_infinite (out_psnr_infinite)
  );

endmodule
`default_nettype wire

// File: design/rmpm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rmpm_datapath import rmpm_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  input  wire logic [7:0]        orig_red,
  input  wire logic [7:0]        orig_green,
  input  wire logic [7:0]        orig_blue,
  input  wire logic [7:0]        proc_red,
  input  wire logic [7:0]        proc_green,
  input  wire logic [7:0]        proc_blue,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic [MSE_W-1:0]       out_mse_red,
  output logic [MSE_W-1:0]       out_mse_green,
  output logic [MSE_W-1:0]       out_mse_blue,
  output logic [PSNR_W-1:0]      out_psnr_db,
  output logic                   out_psnr_infinite
);

  localparam int CW  = MAX_PIXELS_LOG2 + 1;
  localparam int SW  = MAX_PIXELS_LOG2 + 16;
  localparam int DW  = CW + 2;
  localparam int RW  = DW + 1;
  localparam int DVN = SW + 16;
  localparam int XW  = MAX_PIXELS_LOG2 + 19;
  localparam int NW  = (XW > 31) ? XW : 31;
  localparam int EW  = $clog2(NW);
  localparam int LGW = EW + LOG_FRAC;
  localparam int ACW = LGW + 35;

  logic [7:0]  o_px [0:2];
  logic [7:0]  p_px [0:2];
  logic [7:0]  dif  [0:2];
  logic [15:0] sq   [0:2];
  logic [SW-1:0] sum_r   [0:2];
  logic [SW-1:0] sum_nxt [0:2];
  logic [SW-1:0] wk_r    [0:2];
  logic [CW-1:0] cnt_r, cnt_nxt, wk_cnt_r;
  logic          cap_full;

  logic [DW-1:0]  divisor_r;
  logic [RW-1:0]  rem_r, trial;
  logic [DVN-1:0] dvd_r;
  logic           ge;
  logic [SW-1:0]  sel_sum;

  logic [MSE_W-1:0] mse_r [0:2];
  logic [XW-1:0]    num_r;
  logic [SW+1:0]    total_r;
  logic [NW-1:0]    x_r;
  logic [EW-1:0]    sh_r;
  logic [30:0]      m_r;
  logic [61:0]      prod_r;
  logic [31:0]      t_c;
  logic [LOG_FRAC-1:0] frac_r;
  logic [LGW-1:0]   la_r, ls_r, lg_c, dl_r;
  logic             pos_r;
  logic [LGW+16:0]  pp_lo_r, pp_hi_r;
  logic [ACW-1:0]   acc_c, pv_c;
  logic [PSNR_W-1:0] psnr_r;
  logic             out_valid_r;

  assign o_px[0] = orig_red;
  assign o_px[1] = orig_green;
  assign o_px[2] = orig_blue;
  assign p_px[0] = proc_red;
  assign p_px[1] = proc_green;
  assign p_px[2] = proc_blue;

  assign cap_full = cnt_r[CW-1];
  assign cnt_nxt  = cap_full ? cnt_r : cnt_r + 1'b1;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dif[c] = (o_px[c] >= p_px[c]) ? (o_px[c] - p_px[c]) : (p_px[c] - o_px[c]);
      sq[c]  = dif[c] * dif[c];
      sum_nxt[c] = cap_full ? sum_r[c] : sum_r[c] + SW'(sq[c]);
    end
  end

  always_comb begin
    case (cmd.ch)
      2'd0:    sel_sum = wk_r[0];
      2'd1:    sel_sum = wk_r[1];
      default: sel_sum = wk_r[2];
    endcase
  end

  assign trial = {rem_r[RW-2:0], dvd_r[DVN-1]};
  assign ge    = trial >= {1'b0, divisor_r};
  assign t_c   = prod_r[61:30];
  assign lg_c  = {EW'(NW - 1) - sh_r, frac_r};
  assign acc_c = ACW'({pp_hi_r, 17'b0}) + ACW'(pp_lo_r) + (ACW'(1) << 47);
  assign pv_c  = acc_c >> 48;

  // running sums and pixel count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) sum_r[c] <= '0;
      cnt_r <= '0;
    end else if (cmd.accept) begin
      if (cmd.snap) begin
        for (int c = 0; c < 3; c++) sum_r[c] <= '0;
        cnt_r <= '0;
      end else begin
        for (int c = 0; c < 3; c++) sum_r[c] <= sum_nxt[c];
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.snap) begin
      for (int c = 0; c < 3; c++) wk_r[c] <= sum_nxt[c];
      wk_cnt_r <= cnt_nxt;
    end
    case (cmd.op)
      OP_DIV_INIT: begin
        divisor_r <= {2'b00, wk_cnt_r} + {1'b0, wk_cnt_r, 1'b0};
        rem_r     <= '0;
        dvd_r     <= {sel_sum, 16'b0};
      end
      OP_DIV_STEP: begin
        rem_r <= ge ? trial - {1'b0, divisor_r} : trial;
        dvd_r <= {dvd_r[DVN-2:0], ge};
      end
      OP_DIV_STORE: begin
        case (cmd.ch)
          2'd0:    mse_r[0] <= dvd_r[MSE_W-1:0];
          2'd1:    mse_r[1] <= dvd_r[MSE_W-1:0];
          default: mse_r[2] <= dvd_r[MSE_W-1:0];
        endcase
      end
      OP_NUM_MUL: begin
        num_r   <= PEAK_X3 * wk_cnt_r;
        total_r <= (SW+2)'(wk_r[0]) + (SW+2)'(wk_r[1]) + (SW+2)'(wk_r[2]);
      end
      OP_LOG_LOAD: begin
        x_r  <= (cmd.ch == 2'd0) ? NW'(num_r) : NW'(total_r);
        sh_r <= '0;
      end
      OP_LOG_NORM: begin
        x_r  <= {x_r[NW-2:0], 1'b0};
        sh_r <= sh_r + 1'b1;
      end
      OP_LOG_MLOAD: begin
        m_r    <= x_r[NW-1 -: 31];
        frac_r <= '0;
      end
      OP_LOG_SQ: prod_r <= m_r * m_r;
      OP_LOG_FIX: begin
        if (t_c[31]) begin
          m_r    <= t_c[31:1];
          frac_r <= {frac_r[LOG_FRAC-2:0], 1'b1};
        end else begin
          m_r    <= t_c[30:0];
          frac_r <= {frac_r[LOG_FRAC-2:0], 1'b0};
        end
      end
      OP_LOG_STORE: begin
        if (cmd.ch == 2'd0) la_r <= lg_c;
        else ls_r <= lg_c;
      end
      OP_PSNR_DL: begin
        dl_r  <= la_r - ls_r;
        pos_r <= la_r > ls_r;
      end
      OP_PSNR_LO: pp_lo_r <= dl_r * PS_LO;
      OP_PSNR_HI: pp_hi_r <= dl_r * PS_HI;
      OP_PSNR_SUM: begin
        if (!pos_r) psnr_r <= '0;
        else if (pv_c > ACW'(PSNR_MAX)) psnr_r <= PSNR_MAX;
        else psnr_r <= pv_c[PSNR_W-1:0];
      end
      OP_OUT: begin
        out_mse_red       <= mse_r[0];
        out_mse_green     <= mse_r[1];
        out_mse_blue      <= mse_r[2];
        out_psnr_db       <= stat.tot_zero ? '0 : psnr_r;
        out_psnr_infinite <= stat.tot_zero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.norm_top = x_r[NW-1];
  assign stat.tot_zero = (total_r == '0);
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule
`default_nettype wire

// File: design/rmpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rmpm_ctrl import rmpm_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 24
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire logic  in_final_pixel,
  output logic       in_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int DVN  = MAX_PIXELS_LOG2 + 32;
  localparam int CNTW = $clog2(DVN);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DIV_INIT  = 4'd1;
  localparam logic [3:0] S_DIV_STEP  = 4'd2;
  localparam logic [3:0] S_DIV_STORE = 4'd3;
  localparam logic [3:0] S_NUM       = 4'd4;
  localparam logic [3:0] S_CHECK     = 4'd5;
  localparam logic [3:0] S_LOG_LOAD  = 4'd6;
  localparam logic [3:0] S_NORM      = 4'd7;
  localparam logic [3:0] S_SQ        = 4'd8;
  localparam logic [3:0] S_FIX       = 4'd9;
  localparam logic [3:0] S_LOG_STORE = 4'd10;
  localparam logic [3:0] S_DL        = 4'd11;
  localparam logic [3:0] S_PLO       = 4'd12;
  localparam logic [3:0] S_PHI       = 4'd13;
  localparam logic [3:0] S_PSUM      = 4'd14;
  localparam logic [3:0] S_OUT       = 4'd15;

  logic [3:0]      state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      ch_r, ch_nxt;
  logic            acc;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ch_nxt     = ch_r;
    cmd.accept = acc;
    cmd.snap   = acc && in_final_pixel;
    cmd.op     = OP_NONE;
    cmd.ch     = ch_r;
    case (state_r)
      S_IDLE: begin
        if (acc && in_final_pixel) begin
          ch_nxt    = 2'd0;
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DVN - 1)) state_nxt = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        if (ch_r == 2'd2) begin
          state_nxt = S_NUM;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_NUM: begin
        cmd.op    = OP_NUM_MUL;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        ch_nxt    = 2'd0;
        state_nxt = stat.tot_zero ? S_OUT : S_LOG_LOAD;
      end
      S_LOG_LOAD: begin
        cmd.op    = OP_LOG_LOAD;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        // shift until the leading one reaches the top bit
        if (stat.norm_top) begin
          cmd.op    = OP_LOG_MLOAD;
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.op = OP_LOG_NORM;
        end
      end
      S_SQ: begin
        cmd.op    = OP_LOG_SQ;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        cmd.op  = OP_LOG_FIX;
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = (cnt_r == CNTW'(LOG_FRAC - 1)) ? S_LOG_STORE : S_SQ;
      end
      S_LOG_STORE: begin
        cmd.op = OP_LOG_STORE;
        if (ch_r == 2'd0) begin
          ch_nxt    = 2'd1;
          state_nxt = S_LOG_LOAD;
        end else begin
          state_nxt = S_DL;
        end
      end
      S_DL: begin
        cmd.op    = OP_PSNR_DL;
        state_nxt = S_PLO;
      end
      S_PLO: begin
        cmd.op    = OP_PSNR_LO;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.op    = OP_PSNR_HI;
        state_nxt = S_PSUM;
      end
      S_PSUM: begin
        cmd.op    = OP_PSNR_SUM;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ch_r    <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ch_r    <= ch_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/rmpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module rmpm_checker import rmpm_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              in_final_pixel,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [MSE_W-1:0]  out_mse_red,
  input wire logic [MSE_W-1:0]  out_mse_green,
  input wire logic [MSE_W-1:0]  out_mse_blue,
  input wire logic [PSNR_W-1:0] out_psnr_db,
  input wire logic              out_psnr_infinite
);

  // a stalled result stays valid and keeps its red MSE, PSNR and infinite flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_psnr_db)
      && $stable(out_mse_red) && $stable(out_psnr_infinite))
    else $error("stalled result changed");

  // zero error reports zero MSE and zero PSNR field
  a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_psnr_infinite |-> out_mse_red == '0 && out_mse_green == '0
      && out_mse_blue == '0 && out_psnr_db == '0)
    else $error("infinite PSNR with nonzero fields");

  // a final pixel makes the block busy
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_final_pixel |=> in_stall)
    else $error("final pixel did not start computation");

  // a new result only appears at the end of a busy phase
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without computation");

endmodule

bind rgb_mse_psnr_meter rmpm_checker u_rmpm_checker (.*);
`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import rmpm_pkg::*;

  localparam int CAP_LOG2 = 24;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLDOFF_CYCLES = 900;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [63:0] SCALE_Q24 = 64'd12929139865;

  typedef struct packed {
    logic [7:0] o_r, o_g, o_b, p_r, p_g, p_b;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [MSE_W-1:0]  mse_r, mse_g, mse_b;
    logic [PSNR_W-1:0] psnr;
    logic              inf;
  } quality_t;

  class quality_scoreboard;
    logic [63:0] sum_r, sum_g, sum_b, count;
    quality_t    pending_q[$];
    int          errors;
    int          images;
    int          zero_images;

    function new();
      sum_r = 0; sum_g = 0; sum_b = 0; count = 0;
      errors = 0; images = 0; zero_images = 0;
    endfunction

    static function logic [63:0] sq_diff(logic [7:0] a, logic [7:0] b);
      logic [63:0] d;
      d = (a >= b) ? 64'(a - b) : 64'(b - a);
      return d * d;
    endfunction

    static function logic [63:0] log2_q24(logic [63:0] x);
      int unsigned e;
      logic [63:0] m, frac;
      e = 0;
      frac = 0;
      if (x == 0) return 0;
      while (e < 63 && (x >> (e + 1)) != 0) e++;
      if (e >= 30) m = x >> (e - 30);
      else m = x << (30 - e);
      for (int i = 23; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          m = m >> 1;
          frac[i] = 1'b1;
        end
      end
      return (64'(e) << 24) | frac;
    endfunction

    function void note_pixel(pixel_t px);
      quality_t    q;
      logic [63:0] div, total, la, ls, p;
      if (count < (64'd1 << CAP_LOG2)) begin
        sum_r += sq_diff(px.o_r, px.p_r);
        sum_g += sq_diff(px.o_g, px.p_g);
        sum_b += sq_diff(px.o_b, px.p_b);
        count++;
      end
      if (!px.last) return;
      div = 3 * count;
      q.mse_r = MSE_W'((sum_r << 16) / div);
      q.mse_g = MSE_W'((sum_g << 16) / div);
      q.mse_b = MSE_W'((sum_b << 16) / div);
      total = sum_r + sum_g + sum_b;
      if (total == 0) begin
        q.psnr = '0;
        q.inf = 1'b1;
        zero_images++;
      end else begin
        la = log2_q24(64'd195075 * count);
        ls = log2_q24(total);
        if (la <= ls) p = 0;
        else begin
          p = ((la - ls) * SCALE_Q24 + (64'd1 << 47)) >> 48;
          if (p > 64'(PSNR_MAX)) p = 64'(PSNR_MAX);
        end
        q.psnr = PSNR_W'(p);
        q.inf = 1'b0;
      end
      pending_q.push_back(q);
      images++;
      sum_r = 0; sum_g = 0; sum_b = 0; count = 0;
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(quality_t got);
      quality_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result, pending", 1, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.mse_r != want.mse_r) report_mismatch("mse_red", got.mse_r, want.mse_r);
      if (got.mse_g != want.mse_g) report_mismatch("mse_green", got.mse_g, want.mse_g);
      if (got.mse_b != want.mse_b) report_mismatch("mse_blue", got.mse_b, want.mse_b);
      if (got.psnr != want.psnr) report_mismatch("psnr_db", got.psnr, want.psnr);
      if (got.inf != want.inf) report_mismatch("psnr_infinite", got.inf, want.inf);
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_final_pixel;
  logic [7:0] in_orig_red, in_orig_green, in_orig_blue;
  logic [7:0] in_proc_red, in_proc_green, in_proc_blue;
  logic out_valid, out_stall, out_psnr_infinite;
  logic [MSE_W-1:0] out_mse_red, out_mse_green, out_mse_blue;
  logic [PSNR_W-1:0] out_psnr_db;

  quality_scoreboard sb;
  logic holdoff_req;
  logic sending_done;
  int   idle_cycles;
  int   pixels_sent;

  rgb_mse_psnr_meter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_orig_red(in_orig_red), .in_orig_green(in_orig_green),
    .in_orig_blue(in_orig_blue), .in_proc_red(in_proc_red),
    .in_proc_green(in_proc_green), .in_proc_blue(in_proc_blue),
    .in_final_pixel(in_final_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mse_red(out_mse_red), .out_mse_green(out_mse_green),
    .out_mse_blue(out_mse_blue), .out_psnr_db(out_psnr_db),
    .out_psnr_infinite(out_psnr_infinite)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(15, 80);
  endfunction

  // Drive one item and hold it until accepted.
  task automatic send_pixel(pixel_t px);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    {in_orig_red, in_orig_green, in_orig_blue} = {px.o_r, px.o_g, px.o_b};
    {in_proc_red, in_proc_green, in_proc_blue} = {px.p_r, px.p_g, px.p_b};
    in_final_pixel = px.last;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_image(int npix, int mode);
    pixel_t px;
    for (int i = 0; i < npix; i++) begin
      px.o_r = 8'($urandom); px.o_g = 8'($urandom); px.o_b = 8'($urandom);
      case (mode)
        0: {px.p_r, px.p_g, px.p_b} = {px.o_r, px.o_g, px.o_b};
        1: begin
          px.p_r = px.o_r ^ 8'($urandom_range(0, 3));
          px.p_g = px.o_g ^ 8'($urandom_range(0, 3));
          px.p_b = px.o_b ^ 8'($urandom_range(0, 3));
        end
        default: begin
          px.p_r = 8'($urandom); px.p_g = 8'($urandom); px.p_b = 8'($urandom);
        end
      endcase
      px.last = (i == npix - 1);
      send_pixel(px);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_pixel({in_orig_red, in_orig_green, in_orig_blue,
                     in_proc_red, in_proc_green, in_proc_blue, in_final_pixel});
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_mse_red, out_mse_green, out_mse_blue,
                       out_psnr_db, out_psnr_infinite});
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int n;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        out_stall = 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_req = 1'b0;
      end
      n = gap_len();
      out_stall = (n > 0);
      repeat (n > 0 ? n - 1 : $urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int npix, r;
    bit held, drained;
    sb = new();
    held = 1'b0;
    drained = 1'b0;
    holdoff_req = 1'b0;
    sending_done = 1'b0;
    pixels_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_orig_red, in_orig_green, in_orig_blue} = '0;
    {in_proc_red, in_proc_green, in_proc_blue} = '0;
    in_final_pixel = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Directed: worst, zero, mixed-channel, tiny error; short images.
    send_pixel({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 1'b1});
    send_pixel({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1});
    send_pixel({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
    send_pixel({8'd255, 8'd0, 8'd128, 8'd0, 8'd0, 8'd127, 1'b1});
    send_pixel({8'd10, 8'd20, 8'd30, 8'd11, 8'd20, 8'd30, 1'b1});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b0});
    send_pixel({8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1});
    send_pixel({8'd85, 8'd170, 8'd85, 8'd85, 8'd170, 8'd85, 1'b0});
    send_pixel({8'd170, 8'd85, 8'd170, 8'd170, 8'd85, 8'd171, 1'b1});
    send_image(5, 0);
    send_image(4, 2);

    // Random images, mostly small; hold the output back once mid-run.
    while (pixels_sent < 1200) begin
      if (!held && pixels_sent > 300) begin
        holdoff_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && pixels_sent > 700) begin
        // pause until every pending result is drained
        drained = 1'b1;
        in_valid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      npix = (r < 90) ? $urandom_range(1, 8) : $urandom_range(30, 150);
      r = $urandom_range(0, 99);
      send_image(npix, r < 15 ? 0 : (r < 40 ? 1 : 2));
    end
    in_valid = 1'b0;
    sending_done = 1'b1;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d pixels in %0d images, %0d with zero error",
             pixels_sent, sb.images, sb.zero_images);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
